FILE: src/lpe_pkg.sv
// Shared constants, types and helpers of the Legendre/Lobatto evaluator.
package lpe_pkg;

	// Fixed-point format and field widths.
	localparam int FRAC_BITS = 30;
	localparam int MAX_DEGREE_DEF = 63;
	localparam int DEG_W = 6;
	localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(4);
	localparam int POINT_W = 32;
	localparam int LV_W = 32;
	localparam int QV_W = 33;
	localparam int QD_W = 38;

	// Step counter holds k up to degree + 1.
	localparam int K_W = DEG_W + 1;

	// Datapath widths: magnitude of a value in [-1, 1], the product x * L,
	// the recurrence numerator, its magnitude and the reciprocal product.
	localparam int LM_W = LV_W - 1;
	localparam int XP_W = 2 * LM_W;
	localparam int NUM_W = FRAC_BITS + 9;
	localparam int MAG_W = NUM_W - 1;
	localparam int LO_W = 32;
	localparam int HI_W = MAG_W - LO_W;
	localparam int RCP_W = FRAC_BITS;
	localparam int PROD_W = MAG_W + RCP_W;

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MX,
		ST_TERM,
		ST_NUM,
		ST_RMUL,
		ST_RND,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             mul_x;
		logic             term;
		logic             num;
		logic             mul_r;
		logic             round;
		logic             last;
		logic             emit;
		logic [K_W-1:0]   k;
		logic [DEG_W-1:0] n;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} sts_t;

	// Largest degree that the degree register can actually select.
	function automatic int eff_max(input int max_degree);
		int lim;
		lim = (1 << DEG_W) - 1;
		return (max_degree < lim) ? max_degree : lim;
	endfunction

endpackage

FILE: src/lpe_if.sv
// Valid/ready channel interfaces for the evaluation point and the results.
interface lpe_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [lpe_pkg::POINT_W-1:0] point;

	modport source(output valid, output point, input ready);
	modport sink(input valid, input point, output ready);
endinterface

interface lpe_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [lpe_pkg::LV_W-1:0] legendre_value;
	logic signed [lpe_pkg::QV_W-1:0] lobatto_value;
	logic signed [lpe_pkg::QD_W-1:0] lobatto_slope;

	modport source(output valid, output legendre_value, output lobatto_value,
		output lobatto_slope, input ready);
	modport sink(input valid, input legendre_value, input lobatto_value,
		input lobatto_slope, output ready);
endinterface

FILE: src/lpe_ctrl.sv
// Controller: degree register, step counter and the recurrence sequencer.
module lpe_ctrl #(
	parameter int MAX_DEGREE = lpe_pkg::MAX_DEGREE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lpe_pkg::DEG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lpe_pkg::sts_t             sts,
	output lpe_pkg::cmd_t             cmd
);

	localparam int NMAX = lpe_pkg::eff_max(MAX_DEGREE);

	lpe_pkg::state_t state_q, state_d;
	logic [lpe_pkg::DEG_W-1:0] deg_q;
	logic [lpe_pkg::DEG_W-1:0] n_q;
	logic [lpe_pkg::DEG_W-1:0] n_eff;
	logic [lpe_pkg::K_W-1:0]   k_q;
	logic                      last;
	logic                      accept;

	assign accept = in_valid && in_ready;
	assign last = (k_q == ({1'b0, n_q} + lpe_pkg::K_W'(1)));

	// Degree zero acts as one, degrees past the limit act as the limit.
	always_comb begin
		priority if (deg_q == '0) begin
			n_eff = lpe_pkg::DEG_W'(1);
		end else if (deg_q > lpe_pkg::DEG_W'(NMAX)) begin
			n_eff = lpe_pkg::DEG_W'(NMAX);
		end else begin
			n_eff = deg_q;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= lpe_pkg::DEG_RESET;
		end else if (cfg_we) begin
			deg_q <= cfg_wdata;
		end
	end

	// State, degree of the running transaction and step index k.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpe_pkg::ST_IDLE;
			n_q <= lpe_pkg::DEG_W'(1);
			k_q <= lpe_pkg::K_W'(2);
		end else begin
			state_q <= state_d;
			if (accept) begin
				n_q <= n_eff;
				k_q <= lpe_pkg::K_W'(2);
			end else if (state_q == lpe_pkg::ST_RND && !last) begin
				k_q <= k_q + lpe_pkg::K_W'(1);
			end
		end
	end

	// Next state: five states per recurrence step, then the result hand-off.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpe_pkg::ST_IDLE: begin
				if (in_valid) state_d = lpe_pkg::ST_MX;
			end
			lpe_pkg::ST_MX:   state_d = lpe_pkg::ST_TERM;
			lpe_pkg::ST_TERM: state_d = lpe_pkg::ST_NUM;
			lpe_pkg::ST_NUM:  state_d = lpe_pkg::ST_RMUL;
			lpe_pkg::ST_RMUL: state_d = lpe_pkg::ST_RND;
			lpe_pkg::ST_RND: begin
				state_d = last ? lpe_pkg::ST_OUT : lpe_pkg::ST_MX;
			end
			lpe_pkg::ST_OUT: begin
				if (sts.out_free) state_d = lpe_pkg::ST_IDLE;
			end
			default: state_d = lpe_pkg::ST_IDLE;
		endcase
	end

	// Command decode.
	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		cmd.k = k_q;
		cmd.n = n_q;
		cmd.last = last;
		unique case (state_q)
			lpe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lpe_pkg::ST_MX:   cmd.mul_x = 1'b1;
			lpe_pkg::ST_TERM: cmd.term = 1'b1;
			lpe_pkg::ST_NUM:  cmd.num = 1'b1;
			lpe_pkg::ST_RMUL: cmd.mul_r = 1'b1;
			lpe_pkg::ST_RND:  cmd.round = 1'b1;
			lpe_pkg::ST_OUT:  cmd.emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: src/lpe_dp.sv
// Datapath: recurrence registers, shared multiply and round steps, output register.
module lpe_dp #(
	parameter int MAX_DEGREE = lpe_pkg::MAX_DEGREE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lpe_pkg::cmd_t                      cmd,
	output lpe_pkg::sts_t                      sts,
	input  logic signed [lpe_pkg::POINT_W-1:0] point,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lpe_pkg::LV_W-1:0]    legendre_value,
	output logic signed [lpe_pkg::QV_W-1:0]    lobatto_value,
	output logic signed [lpe_pkg::QD_W-1:0]    lobatto_slope
);

	localparam int NMAX = lpe_pkg::eff_max(MAX_DEGREE);
	localparam int KIW = $clog2(NMAX + 2);
	localparam int TAB_N = 1 << KIW;
	localparam int LV_W = lpe_pkg::LV_W;
	localparam int LM_W = lpe_pkg::LM_W;
	localparam int NUM_W = lpe_pkg::NUM_W;
	localparam int MAG_W = lpe_pkg::MAG_W;
	localparam int LO_W = lpe_pkg::LO_W;
	localparam int HI_W = lpe_pkg::HI_W;
	localparam int RCP_W = lpe_pkg::RCP_W;
	localparam int PROD_W = lpe_pkg::PROD_W;
	localparam int XP_W = lpe_pkg::XP_W;
	localparam int FB = lpe_pkg::FRAC_BITS;
	localparam int K_W = lpe_pkg::K_W;
	localparam logic signed [LV_W-1:0] ONE_L = LV_W'(lpe_pkg::ONE);
	localparam logic [LM_W-1:0] ONE_M = LM_W'(lpe_pkg::ONE);

	// Reciprocal table: 1/k rounded to nearest, entries below two unused.
	logic [RCP_W-1:0] rcp_tab [TAB_N];
	for (genvar g = 0; g < TAB_N; g++) begin : g_rcp
		localparam longint RV = (g < 2) ? 0 :
			(lpe_pkg::ONE + g / 2) / ((g < 2) ? 1 : g);
		assign rcp_tab[g] = RV[RCP_W-1:0];
	end

	logic signed [LV_W-1:0]   x_q, prev_q, cur_q, nxt_q;
	logic [XP_W-1:0]          prod_q;
	logic                     psgn_q;
	logic [NUM_W-1:0]         t1_q;
	logic signed [NUM_W-1:0]  t2_q;
	logic [MAG_W-1:0]         nmag_q;
	logic                     nneg_q;
	logic [LO_W+RCP_W-1:0]    pl_q;
	logic [HI_W+RCP_W-1:0]    ph_q;
	logic                     ov_q;

	logic signed [LV_W-1:0]   x_sat;
	logic [LM_W-1:0]          xm, lm, rnd, smag;
	logic [XP_W-1:0]          psum;
	logic [K_W:0]             kx2m1;
	logic [K_W-1:0]           km1;
	logic signed [K_W:0]      km1_s;
	logic [NUM_W-1:0]         t1_d;
	logic signed [NUM_W-1:0]  t2_d, s;
	logic [RCP_W-1:0]         rcp;
	logic [PROD_W-1:0]        total;
	logic [MAG_W-1:0]         rmag;
	logic signed [LV_W-1:0]   lnew;
	logic [K_W-1:0]           n2p1;
	logic signed [lpe_pkg::QD_W-1:0] slope_d;

	// Point is clamped to [-1, 1] on entry.
	always_comb begin
		priority if (point > ONE_L) begin
			x_sat = ONE_L;
		end else if (point < -ONE_L) begin
			x_sat = -ONE_L;
		end else begin
			x_sat = point;
		end
	end

	// Magnitudes for the x * L_{k-1} product.
	assign xm = x_q[LV_W-1] ? LM_W'(-x_q) : LM_W'(x_q);
	assign lm = cur_q[LV_W-1] ? LM_W'(-cur_q) : LM_W'(cur_q);

	// Rounded product times (2k-1), and (k-1) times L_{k-2}.
	assign psum = prod_q + XP_W'(lpe_pkg::HALF);
	assign rnd = psum[FB +: LM_W];
	assign kx2m1 = {cmd.k, 1'b0} - (K_W + 1)'(1);
	assign km1 = cmd.k - K_W'(1);
	assign km1_s = {1'b0, km1};
	assign t1_d = rnd * kx2m1;
	assign t2_d = prev_q * km1_s;

	// Signed numerator; the sign of x * L_{k-1} folds into the add.
	assign s = psgn_q ? (signed'(t1_q) + t2_q) : (signed'(t1_q) - t2_q);

	// Reciprocal lookup and the rounded, clamped quotient.
	assign rcp = rcp_tab[cmd.k[KIW-1:0]];
	assign total = PROD_W'(pl_q) + {ph_q, LO_W'(0)} + PROD_W'(lpe_pkg::HALF);
	assign rmag = total[PROD_W-1:FB];
	assign smag = (rmag > MAG_W'(ONE_M)) ? ONE_M : rmag[LM_W-1:0];
	assign lnew = nneg_q ? -signed'({1'b0, smag}) : signed'({1'b0, smag});

	// Derivative factor 2N+1.
	assign n2p1 = {cmd.n, 1'b0} + K_W'(1);
	assign slope_d = cur_q * signed'({1'b0, n2p1});

	// Recurrence and arithmetic registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_sat;
			prev_q <= ONE_L;
			cur_q <= x_sat;
		end
		if (cmd.mul_x) begin
			prod_q <= xm * lm;
			psgn_q <= x_q[LV_W-1] ^ cur_q[LV_W-1];
		end
		if (cmd.term) begin
			t1_q <= t1_d;
			t2_q <= t2_d;
		end
		if (cmd.num) begin
			nneg_q <= psgn_q ^ s[NUM_W-1];
			nmag_q <= s[NUM_W-1] ? MAG_W'(-s) : MAG_W'(s);
		end
		if (cmd.mul_r) begin
			pl_q <= nmag_q[LO_W-1:0] * rcp;
			ph_q <= nmag_q[MAG_W-1:LO_W] * rcp;
		end
		if (cmd.round) begin
			if (cmd.last) begin
				nxt_q <= lnew;
			end else begin
				prev_q <= cur_q;
				cur_q <= lnew;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			legendre_value <= cur_q;
			lobatto_value <= lpe_pkg::QV_W'(nxt_q) - lpe_pkg::QV_W'(prev_q);
			lobatto_slope <= slope_d;
		end
	end

	// Output valid: set by a new result, cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign sts.out_free = !ov_q || out_ready;

endmodule

FILE: src/legendre_lobatto_poly_eval.sv
// Top level of the Legendre/Lobatto polynomial evaluator.
// For each point x (Q30, clamped to [-1, 1]) the block runs the three-term
// Legendre recurrence up to the configured degree N and returns L_N(x),
// L_{N+1}(x) - L_{N-1}(x) and (2N+1) L_N(x), all Q30. A degree of zero acts
// as one, and degrees above MAX_DEGREE act as MAX_DEGREE. One transaction is
// processed at a time: after the load it takes N recurrence steps, each through
// the shared multiply, term, numerator, reciprocal-multiply and round states,
// then hands the result to the output register before a new point is taken.
// The output register lets the next point enter while the previous result
// still waits. Write the degree register only while no transaction is in progress.
module legendre_lobatto_poly_eval #(
	parameter int MAX_DEGREE = lpe_pkg::MAX_DEGREE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lpe_pkg::DEG_W-1:0] cfg_wdata,
	lpe_in_if.sink                    sample,
	lpe_out_if.source                 result
);

	lpe_pkg::cmd_t cmd;
	lpe_pkg::sts_t sts;

	// Sequencer.
	lpe_ctrl #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic and result register.
	lpe_dp #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.point         (sample.point),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.legendre_value(result.legendre_value),
		.lobatto_value (result.lobatto_value),
		.lobatto_slope (result.lobatto_slope)
	);

endmodule

FILE: src/lpe_chk.sv
// Port-level assertions for the evaluator, bound to the top level.
module lpe_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [lpe_pkg::LV_W-1:0] legendre_value,
	input logic signed [lpe_pkg::QV_W-1:0] lobatto_value,
	input logic signed [lpe_pkg::QD_W-1:0] lobatto_slope
);

	// Only one transaction is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a transaction is in progress");

	// A result never appears the cycle right after a point is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |=> !out_valid)
		else $error("result appeared without running the recurrence");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(legendre_value)
			&& $stable(lobatto_value) && $stable(lobatto_slope)))
		else $error("stalled result changed or dropped");

	// L_N stays within [-1, 1].
	a_legendre_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((legendre_value <= lpe_pkg::LV_W'(lpe_pkg::ONE))
			&& (legendre_value >= -lpe_pkg::LV_W'(lpe_pkg::ONE))))
		else $error("legendre_value outside [-1, 1]");

endmodule

bind legendre_lobatto_poly_eval lpe_chk u_lpe_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.legendre_value(result.legendre_value),
	.lobatto_value (result.lobatto_value),
	.lobatto_slope (result.lobatto_slope)
);
